@@ sv/sid_pkg.sv @@
// Shared types and constants for the signed integer to decimal text unit.
// No dependencies; imported by sid_digit_cell and the top level.
package sid_pkg;

  // Default width of the signed input word.
  localparam int DEFAULT_VALUE_WIDTH = 32;

  // Bits in one BCD digit cell.
  localparam int BCD_WIDTH = 4;

  // ASCII codes that the unit emits.
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_ZERO  = 7'd48;

  // Largest value a BCD digit may hold.
  localparam logic [BCD_WIDTH-1:0] DIGIT_MAX = 4'd9;

  // Per-cycle command shared by every digit cell of the chain.
  typedef struct packed {
    logic clear;  // start of a new word: all digits to zero
    logic conv;   // double-dabble step: adjust and shift one bit in
    logic shift;  // emit step: take the digit of the lower neighbor
  } cell_ctrl_t;

endpackage

@@ sv/sid_digit_cell.sv @@
// One BCD digit cell of the double-dabble chain.
// Depends on sid_pkg for the cell command struct and digit width.
module sid_digit_cell (
  input  logic                           clk,
  input  sid_pkg::cell_ctrl_t            ctrl,
  input  logic                           carry_in,
  input  logic [sid_pkg::BCD_WIDTH-1:0]  digit_in,
  output logic [sid_pkg::BCD_WIDTH-1:0]  digit,
  output logic                           carry_out
);
  import sid_pkg::*;

  logic [BCD_WIDTH-1:0] adj;

  // Add three when the digit is five or more, so the shift doubles it in BCD.
  assign adj       = (digit > 4'd4) ? (digit + 4'd3) : digit;
  assign carry_out = adj[BCD_WIDTH-1];

  // The digit register follows the command of the controller.
  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv) begin
      digit <= {adj[BCD_WIDTH-2:0], carry_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end else begin
      digit <= digit;
    end
  end

endmodule

@@ sv/signed_int_to_decimal_ascii_unit.sv @@
// Top level of the signed integer to decimal ASCII text unit.
// Depends on sid_pkg and sid_digit_cell.
//
// Usage:
//   The input channel (in_valid, in_stall, value) takes one signed word of
//   VALUE_WIDTH bits. The output channel (out_valid, out_stall, char_code,
//   last_char) gives the decimal text of that word, one ASCII character per
//   word, most significant first. A negative value starts with '-', zero
//   gives a single '0', and last_char marks the final character.
//   The magnitude is shifted bit-serially through a chain of BCD digit cells
//   (double dabble), one bit per cycle. The same chain then shifts the
//   digits upward, one per cycle while the output is not stalled, to the
//   output register; leading zeros are dropped there. At 32 bits the chain
//   has 11 digit cells. A minus sign is loaded into the output register once
//   the conversion has ended, and the first digit only after the sign (later
//   still when leading zeros are dropped).
//   in_stall is high from acceptance until the last character has been loaded
//   into the output register; the output word can still wait while the next
//   input word is taken. A stalled output holds its word and pauses emission.
//   Reset clears the controller and the output valid; no word is in flight.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_WIDTH = sid_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             char_code,
  output logic                   last_char
);
  import sid_pkg::*;

  // Digit cells: decimal digits of 2^(VALUE_WIDTH-1) plus one spare.
  localparam int NUM_DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 2;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                  state;
  logic [VALUE_WIDTH-1:0]  mag;
  logic [CNT_W-1:0]        bit_cnt;
  logic [REM_W-1:0]        rem;
  logic                    sign_pending;
  logic                    started;

  logic                    accept;
  logic                    slot_free;
  logic                    sign_fire;
  logic                    fire;
  logic                    skip;
  cell_ctrl_t              cell_ctrl;
  logic [BCD_WIDTH-1:0]    digit_w [NUM_DIGITS];
  logic                    carry_w [NUM_DIGITS];
  logic [BCD_WIDTH-1:0]    top_digit;

  // Handshake and step qualifiers.
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign top_digit = digit_w[NUM_DIGITS-1];
  assign sign_fire = (state == ST_EMIT) && sign_pending && slot_free;
  assign fire      = (state == ST_EMIT) && !sign_pending && slot_free;
  assign skip      = !started && (top_digit == '0) && (rem > REM_W'(1));

  assign cell_ctrl.clear = accept;
  assign cell_ctrl.conv  = (state == ST_CONV);
  assign cell_ctrl.shift = fire;

  // Chain of digit cells; cell 0 is the least significant digit.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic                 cin;
    logic [BCD_WIDTH-1:0] din;
    if (i == 0) begin : g_first
      assign cin = mag[VALUE_WIDTH-1];
      assign din = '0;
    end else begin : g_rest
      assign cin = carry_w[i-1];
      assign din = digit_w[i-1];
    end
    sid_digit_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .carry_in  (cin),
      .digit_in  (din),
      .digit     (digit_w[i]),
      .carry_out (carry_w[i])
    );
  end

  // Controller: load, bit-serial conversion, then digit emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sign_pending <= 1'b0;
      started      <= 1'b0;
      bit_cnt      <= '0;
      rem          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state        <= ST_CONV;
            sign_pending <= value[VALUE_WIDTH-1];
            started      <= 1'b0;
            bit_cnt      <= CNT_W'(VALUE_WIDTH);
          end
        end
        ST_CONV: begin
          bit_cnt <= bit_cnt - CNT_W'(1);
          if (bit_cnt == CNT_W'(1)) begin
            state <= ST_EMIT;
            rem   <= REM_W'(NUM_DIGITS);
          end
        end
        ST_EMIT: begin
          if (sign_fire) begin
            sign_pending <= 1'b0;
          end
          if (fire) begin
            rem <= rem - REM_W'(1);
            if (!skip) begin
              started <= 1'b1;
            end
            if (rem == REM_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Magnitude shift register; the two's complement negate is exact in
  // VALUE_WIDTH unsigned bits, including the most negative value.
  always_ff @(posedge clk) begin
    if (accept) begin
      mag <= value[VALUE_WIDTH-1] ? (~$unsigned(value) + VALUE_WIDTH'(1))
                                  : $unsigned(value);
    end else if (state == ST_CONV) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  // Output register: a new word loads when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (sign_fire || (fire && !skip)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sign_fire) begin
      char_code <= CHAR_MINUS;
      last_char <= 1'b0;
    end else if (fire && !skip) begin
      char_code <= CHAR_ZERO + 7'(top_digit);
      last_char <= (rem == REM_W'(1));
    end
  end

  // Checks on the controller and the digit chain.
  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (bit_cnt != '0))
    else $error("conversion running with a zero bit count");

  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CONV))
    else $error("accepted word did not start conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (char_code == CHAR_MINUS)) |-> !last_char)
    else $error("minus sign flagged as last character");

  a_top_bcd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (top_digit <= DIGIT_MAX))
    else $error("top digit cell holds a non-decimal code");

endmodule
